[sv/filter_expression_lexer_top_defines.svh]
// ----------------------------------------------------------------------------
// Filter expression lexer assertion macros
// Concurrent check macros used by the lexer top level.
// ----------------------------------------------------------------------------
`ifndef FILTER_EXPRESSION_LEXER_TOP_DEFINES_SVH
`define FILTER_EXPRESSION_LEXER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define FEL_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define FEL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FEL_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define FEL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[sv/fel_pkg.sv]
// ----------------------------------------------------------------------------
// Filter expression lexer package
// Shared constants, codes, character classification and control structs.
// ----------------------------------------------------------------------------
package fel_pkg;

    localparam int TEXT_MAX   = 32;
    localparam int POS_WIDTH  = 16;
    localparam int TEXT_IDX_W = $clog2(TEXT_MAX);
    localparam int TEXT_CNT_W = $clog2(TEXT_MAX + 1);
    localparam int INT_WIDTH  = 63;
    localparam int ACC_WIDE_W = INT_WIDTH + 4;

    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
    localparam logic [INT_WIDTH-1:0] INT_MAX = {INT_WIDTH{1'b1}};

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_D  = 8'h64;
    localparam logic [7:0] CH_E  = 8'h65;
    localparam logic [7:0] CH_R  = 8'h72;

    typedef enum logic [3:0] {
        K_LPAR, K_RPAR, K_LSQUARE, K_RSQUARE, K_COMMA, K_SEMICOLON, K_COLON,
        K_DOLLAR, K_DER, K_IDENT, K_INT, K_REGEX, K_EOF, K_ERROR
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE, ERR_UNEXPECTED, ERR_REGEX_EOF
    } err_t;

    typedef enum logic [2:0] {
        M_NORMAL, M_IDENT, M_NUMBER, M_REGEX, M_END
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_READ, ST_SEND
    } state_t;

    typedef enum logic [2:0] {
        CC_NUL, CC_SPACE, CC_ALPHA, CC_DIGIT, CC_DOT, CC_SLASH, CC_SYM, CC_OTHER
    } cclass_t;

    typedef struct packed {
        cclass_t cur_class;
        cclass_t nxt_class;
        kind_t   cur_sym;
        logic    out_last;
    } fel_status_t;

    typedef struct packed {
        logic  shift;
        logic  advance;
        logic  mark_start;
        logic  mark_stop;
        logic  text_clear;
        logic  text_push;
        logic  acc_clear;
        logic  acc_step;
        logic  tok_load;
        kind_t tok_kind;
        err_t  tok_err;
        logic  tok_text;
        logic  tok_int;
        logic  idx_clear;
        logic  idx_inc;
        logic  read_en;
        logic  load_out;
    } fel_cmd_t;

    function automatic cclass_t char_class(input logic [7:0] c);
        cclass_t cls;
        case (c) inside
            8'h00:                                        cls = CC_NUL;
            8'h20, [8'h09:8'h0D]:                         cls = CC_SPACE;
            [8'h61:8'h7A], [8'h41:8'h5A], 8'h5F:          cls = CC_ALPHA;
            [8'h30:8'h39]:                                cls = CC_DIGIT;
            8'h2E:                                        cls = CC_DOT;
            8'h2F:                                        cls = CC_SLASH;
            8'h28, 8'h29, 8'h5B, 8'h5D, 8'h2C, 8'h3B,
            8'h3A, 8'h24:                                 cls = CC_SYM;
            default:                                      cls = CC_OTHER;
        endcase
        return cls;
    endfunction

    function automatic kind_t sym_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            8'h28:   k = K_LPAR;
            8'h29:   k = K_RPAR;
            8'h5B:   k = K_LSQUARE;
            8'h5D:   k = K_RSQUARE;
            8'h2C:   k = K_COMMA;
            8'h3B:   k = K_SEMICOLON;
            8'h3A:   k = K_COLON;
            8'h24:   k = K_DOLLAR;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

endpackage

[sv/fel_ctrl.sv]
// ----------------------------------------------------------------------------
// Filter expression lexer controller
// Handshake sequencer and lexer mode machine; drives datapath commands.
// ----------------------------------------------------------------------------
module fel_ctrl import fel_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  fel_status_t status,
    output fel_cmd_t    cmd
);

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic   primed_reg;
    logic   accept;

    // Per-byte decode results
    logic   dec_emit;
    kind_t  dec_kind;
    err_t   dec_err;
    logic   dec_text;
    logic   dec_int;
    logic   dec_mark_start;
    logic   dec_mark_stop;
    logic   dec_text_clear;
    logic   dec_text_push;
    logic   dec_acc_clear;
    logic   dec_acc_step;
    logic   ident_cont;

    assign accept     = s_valid && (state_reg == ST_IDLE);
    assign ident_cont = (status.nxt_class == CC_ALPHA) || (status.nxt_class == CC_DIGIT) ||
                        (status.nxt_class == CC_DOT);

    // Decode the current byte against the lexer mode
    always_comb begin
        dec_emit       = 1'b0;
        dec_kind       = K_EOF;
        dec_err        = ERR_NONE;
        dec_text       = 1'b0;
        dec_int        = 1'b0;
        dec_mark_start = 1'b0;
        dec_mark_stop  = 1'b0;
        dec_text_clear = 1'b0;
        dec_text_push  = 1'b0;
        dec_acc_clear  = 1'b0;
        dec_acc_step   = 1'b0;
        mode_next      = mode_reg;
        case (mode_reg)
            M_NORMAL: begin
                if (status.cur_class != CC_SPACE) begin
                    dec_mark_start = 1'b1;
                    dec_mark_stop  = 1'b1;
                    case (status.cur_class)
                        CC_ALPHA: begin
                            dec_text_clear = 1'b1;
                            dec_text_push  = 1'b1;
                            if (!ident_cont) begin
                                dec_emit = 1'b1;
                                dec_kind = K_IDENT;
                                dec_text = 1'b1;
                            end else begin
                                mode_next = M_IDENT;
                            end
                        end
                        CC_DIGIT: begin
                            dec_acc_clear = 1'b1;
                            dec_acc_step  = 1'b1;
                            if (status.nxt_class != CC_DIGIT) begin
                                dec_emit = 1'b1;
                                dec_kind = K_INT;
                                dec_int  = 1'b1;
                            end else begin
                                mode_next = M_NUMBER;
                            end
                        end
                        CC_SLASH: begin
                            dec_text_clear = 1'b1;
                            mode_next      = M_REGEX;
                        end
                        CC_NUL: begin
                            dec_emit  = 1'b1;
                            dec_kind  = K_EOF;
                            mode_next = M_END;
                        end
                        CC_SYM: begin
                            dec_emit = 1'b1;
                            dec_kind = status.cur_sym;
                        end
                        default: begin
                            dec_emit = 1'b1;
                            dec_kind = K_ERROR;
                            dec_err  = ERR_UNEXPECTED;
                        end
                    endcase
                end
            end
            M_IDENT: begin
                dec_mark_stop = 1'b1;
                dec_text_push = 1'b1;
                if (!ident_cont) begin
                    dec_emit  = 1'b1;
                    dec_kind  = K_IDENT;
                    dec_text  = 1'b1;
                    mode_next = M_NORMAL;
                end
            end
            M_NUMBER: begin
                if (status.cur_class == CC_DIGIT) begin
                    dec_mark_stop = 1'b1;
                    dec_acc_step  = 1'b1;
                end
                if (status.nxt_class != CC_DIGIT) begin
                    dec_mark_stop = 1'b1;
                    dec_emit      = 1'b1;
                    dec_kind      = K_INT;
                    dec_int       = 1'b1;
                    mode_next     = M_NORMAL;
                end
            end
            M_REGEX: begin
                if (status.cur_class == CC_SLASH) begin
                    dec_mark_stop = 1'b1;
                    dec_emit      = 1'b1;
                    dec_kind      = K_REGEX;
                    dec_text      = 1'b1;
                    mode_next     = M_NORMAL;
                end else if (status.cur_class == CC_NUL) begin
                    dec_mark_stop = 1'b1;
                    dec_emit      = 1'b1;
                    dec_kind      = K_ERROR;
                    dec_err       = ERR_REGEX_EOF;
                    mode_next     = M_END;
                end else begin
                    dec_text_push = 1'b1;
                end
            end
            default: begin
                // end of input reached: repeat eof
                dec_emit = 1'b1;
                dec_kind = K_EOF;
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && primed_reg && dec_emit) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_ready) begin
                    state_next = status.out_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb begin
        cmd = '0;
        cmd.tok_kind = dec_kind;
        cmd.tok_err  = dec_err;
        cmd.tok_text = dec_text;
        cmd.tok_int  = dec_int;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.shift = 1'b1;
                    if (primed_reg) begin
                        cmd.advance    = 1'b1;
                        cmd.mark_start = dec_mark_start;
                        cmd.mark_stop  = dec_mark_stop;
                        cmd.text_clear = dec_text_clear;
                        cmd.text_push  = dec_text_push;
                        cmd.acc_clear  = dec_acc_clear;
                        cmd.acc_step   = dec_acc_step;
                        cmd.tok_load   = dec_emit;
                        cmd.idx_clear  = dec_emit;
                    end
                end
            end
            ST_READ: begin
                cmd.read_en  = 1'b1;
                cmd.load_out = 1'b1;
            end
            ST_SEND: begin
                cmd.idx_inc = m_ready && !status.out_last;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_SEND);

    // Hold state, mode and priming flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mode_reg   <= M_NORMAL;
            primed_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                primed_reg <= 1'b1;
                if (primed_reg) begin
                    mode_reg <= mode_next;
                end
            end
        end
    end

endmodule

[sv/fel_dp.sv]
// ----------------------------------------------------------------------------
// Filter expression lexer datapath
// Lookahead, position counters, text buffer, integer accumulator and the
// result register.
// ----------------------------------------------------------------------------
module fel_dp import fel_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [7:0]            s_ch,
    input  fel_cmd_t              cmd,
    output fel_status_t           status,
    output logic [3:0]            m_kind,
    output logic [1:0]            m_error_code,
    output logic [POS_WIDTH-1:0]  m_begin_line,
    output logic [POS_WIDTH-1:0]  m_begin_col,
    output logic [POS_WIDTH-1:0]  m_end_line,
    output logic [POS_WIDTH-1:0]  m_end_col,
    output logic [INT_WIDTH-1:0]  m_int_value,
    output logic [7:0]            m_text_byte,
    output logic [TEXT_CNT_W-1:0] m_text_length,
    output logic                  m_text_truncated,
    output logic                  m_last
);

    // Lexer state
    logic [7:0]            look_reg;
    logic [POS_WIDTH-1:0]  line_reg, line_next;
    logic [POS_WIDTH-1:0]  col_reg, col_next;
    logic [POS_WIDTH-1:0]  sline_reg, scol_reg, eline_reg, ecol_reg;
    logic [TEXT_CNT_W-1:0] cnt_reg, cnt_base;
    logic                  ovf_reg, ovf_base;
    logic                  der_reg, der_next;
    logic [INT_WIDTH-1:0]  acc_reg, acc_base, acc_next;
    logic [ACC_WIDE_W-1:0] acc_wide;
    logic                  push_ok;

    logic [7:0]            text_mem [TEXT_MAX];

    // Token and emission registers
    kind_t                 tok_kind_reg;
    err_t                  tok_err_reg;
    logic                  tok_text_reg;
    logic                  tok_int_reg;
    logic [TEXT_IDX_W-1:0] idx_reg;
    logic [7:0]            rd_data_reg;
    logic [TEXT_CNT_W-1:0] n_now;
    logic [TEXT_CNT_W-1:0] runs_now;
    logic                  der_hit;

    kind_t                 out_kind_reg;
    err_t                  out_err_reg;
    logic [POS_WIDTH-1:0]  out_bline_reg, out_bcol_reg, out_eline_reg, out_ecol_reg;
    logic [INT_WIDTH-1:0]  out_int_reg;
    logic [TEXT_CNT_W-1:0] out_len_reg;
    logic                  out_trunc_reg;
    logic                  out_last_reg;

    // Status back to the controller
    assign status.cur_class = char_class(look_reg);
    assign status.nxt_class = char_class(s_ch);
    assign status.cur_sym   = sym_kind(look_reg);
    assign status.out_last  = out_last_reg;

    // Advance line and column, saturating
    always_comb begin
        line_next = line_reg;
        col_next  = col_reg;
        if (cmd.advance) begin
            if (col_reg != POS_MAX) begin
                col_next = col_reg + POS_WIDTH'(1);
            end
            if (look_reg == CH_LF) begin
                col_next = '0;
                if (line_reg != POS_MAX) begin
                    line_next = line_reg + POS_WIDTH'(1);
                end
            end
        end
    end

    // Text buffer fill and keyword match
    assign cnt_base = cmd.text_clear ? '0 : cnt_reg;
    assign ovf_base = cmd.text_clear ? 1'b0 : ovf_reg;
    assign push_ok  = cnt_base < TEXT_CNT_W'(TEXT_MAX);

    always_comb begin
        if (cnt_base == TEXT_CNT_W'(0)) begin
            der_next = (look_reg == CH_D);
        end else if (cnt_base == TEXT_CNT_W'(1)) begin
            der_next = der_reg && (look_reg == CH_E);
        end else if (cnt_base == TEXT_CNT_W'(2)) begin
            der_next = der_reg && (look_reg == CH_R);
        end else begin
            der_next = 1'b0;
        end
    end

    // Decimal accumulate with saturation: acc * 10 + digit
    assign acc_base = cmd.acc_clear ? '0 : acc_reg;
    assign acc_wide = (ACC_WIDE_W'(acc_base) << 3) + (ACC_WIDE_W'(acc_base) << 1) +
                      ACC_WIDE_W'(look_reg[3:0]);
    assign acc_next = (|acc_wide[ACC_WIDE_W-1:INT_WIDTH]) ? INT_MAX
                                                          : acc_wide[INT_WIDTH-1:0];

    // Update lexer state on each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            look_reg  <= '0;
            line_reg  <= POS_WIDTH'(1);
            col_reg   <= '0;
            sline_reg <= POS_WIDTH'(1);
            scol_reg  <= '0;
            eline_reg <= POS_WIDTH'(1);
            ecol_reg  <= '0;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            der_reg   <= 1'b0;
            acc_reg   <= '0;
        end else begin
            if (cmd.shift) begin
                look_reg <= s_ch;
            end
            line_reg <= line_next;
            col_reg  <= col_next;
            if (cmd.mark_start) begin
                sline_reg <= line_next;
                scol_reg  <= col_next;
            end
            if (cmd.mark_stop) begin
                eline_reg <= line_next;
                ecol_reg  <= col_next;
            end
            if (cmd.text_push) begin
                if (push_ok) begin
                    cnt_reg <= cnt_base + TEXT_CNT_W'(1);
                    der_reg <= der_next;
                    ovf_reg <= ovf_base;
                end else begin
                    cnt_reg <= cnt_base;
                    ovf_reg <= 1'b1;
                end
            end else if (cmd.text_clear) begin
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
            end
            if (cmd.acc_step) begin
                acc_reg <= acc_next;
            end
        end
    end

    // Text buffer memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (cmd.text_push && push_ok) begin
            text_mem[cnt_base[TEXT_IDX_W-1:0]] <= look_reg;
        end
        if (cmd.read_en) begin
            rd_data_reg <= text_mem[idx_reg];
        end
    end

    // Capture token description and step through its text
    always_ff @(posedge aclk) begin
        if (cmd.tok_load) begin
            tok_kind_reg <= cmd.tok_kind;
            tok_err_reg  <= cmd.tok_err;
            tok_text_reg <= cmd.tok_text;
            tok_int_reg  <= cmd.tok_int;
        end
        if (cmd.idx_clear) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + TEXT_IDX_W'(1);
        end
    end

    assign n_now    = tok_text_reg ? cnt_reg : '0;
    assign runs_now = (n_now == '0) ? TEXT_CNT_W'(1) : n_now;
    assign der_hit  = der_reg && !ovf_reg && (cnt_reg == TEXT_CNT_W'(3));

    // Load the result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_kind_reg  <= (tok_kind_reg == K_IDENT && der_hit) ? K_DER : tok_kind_reg;
            out_err_reg   <= tok_err_reg;
            out_bline_reg <= sline_reg;
            out_bcol_reg  <= scol_reg;
            out_eline_reg <= eline_reg;
            out_ecol_reg  <= ecol_reg;
            out_int_reg   <= tok_int_reg ? acc_reg : '0;
            out_len_reg   <= n_now;
            out_trunc_reg <= tok_text_reg && ovf_reg;
            out_last_reg  <= (TEXT_CNT_W'(idx_reg) + TEXT_CNT_W'(1)) == runs_now;
        end
    end

    assign m_kind           = out_kind_reg;
    assign m_error_code     = out_err_reg;
    assign m_begin_line     = out_bline_reg;
    assign m_begin_col      = out_bcol_reg;
    assign m_end_line       = out_eline_reg;
    assign m_end_col        = out_ecol_reg;
    assign m_int_value      = out_int_reg;
    assign m_text_byte      = (out_len_reg != '0) ? rd_data_reg : 8'h00;
    assign m_text_length    = out_len_reg;
    assign m_text_truncated = out_trunc_reg;
    assign m_last           = out_last_reg;

endmodule

[sv/filter_expression_lexer_top.sv]
// ----------------------------------------------------------------------------
// Filter expression lexer top level
// Byte-in, token-out lexer with one byte of lookahead.
// ----------------------------------------------------------------------------
// The first byte after reset only loads the lookahead and produces nothing.
// Every later byte is taken in the idle state; a byte that ends no token
// (blank, or inside an identifier, number or regex) is done as it is taken
// and the next byte can be taken right after. A byte that ends a token
// starts a run of results, one per buffered text byte (one result for
// tokens without text). For each result the text buffer is read, then the
// result is presented and held while m_ready stays low; no byte is taken
// until the run's last result has been transferred.
// ----------------------------------------------------------------------------
`include "filter_expression_lexer_top_defines.svh"

module filter_expression_lexer_top import fel_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_ch,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_kind,
    output logic [1:0]            m_error_code,
    output logic [POS_WIDTH-1:0]  m_begin_line,
    output logic [POS_WIDTH-1:0]  m_begin_col,
    output logic [POS_WIDTH-1:0]  m_end_line,
    output logic [POS_WIDTH-1:0]  m_end_col,
    output logic [INT_WIDTH-1:0]  m_int_value,
    output logic [7:0]            m_text_byte,
    output logic [TEXT_CNT_W-1:0] m_text_length,
    output logic                  m_text_truncated,
    output logic                  m_last
);

    fel_cmd_t    cmd;
    fel_status_t status;

    // Sequencer and mode machine
    fel_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Lexer state and result register
    fel_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_ch             (s_ch),
        .cmd              (cmd),
        .status           (status),
        .m_kind           (m_kind),
        .m_error_code     (m_error_code),
        .m_begin_line     (m_begin_line),
        .m_begin_col      (m_begin_col),
        .m_end_line       (m_end_line),
        .m_end_col        (m_end_col),
        .m_int_value      (m_int_value),
        .m_text_byte      (m_text_byte),
        .m_text_length    (m_text_length),
        .m_text_truncated (m_text_truncated),
        .m_last           (m_last)
    );

    // Input is never taken while a result is on offer
    `FEL_ASSERT_IMPLY(a_no_overlap, aclk, aresetn, s_ready, !m_valid, "input ready during result")

    // A run that is not finished keeps the input closed
    `FEL_ASSERT_NEXT(a_run_holds, aclk, aresetn, m_valid && m_ready && !m_last, !s_ready, "input opened mid-run")

    // Text length never exceeds the buffer
    `FEL_ASSERT_IMPLY(a_len_bound, aclk, aresetn, m_valid, m_text_length <= TEXT_CNT_W'(TEXT_MAX), "text length too large")

    // Tokens without text are single results
    `FEL_ASSERT_IMPLY(a_single_run, aclk, aresetn, m_valid && (m_kind != K_IDENT) && (m_kind != K_DER) && (m_kind != K_REGEX), m_last && (m_text_length == '0), "textless token not single")

endmodule

[tb/tb_filter_expression_lexer_top.sv]
// ----------------------------------------------------------------------------
// Filter expression lexer testbench
// Streams source bytes into the lexer with random gaps and result-side
// stalls. Each accepted byte updates a token predictor, and every result
// transfer is checked against the oldest predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_filter_expression_lexer_top;
    import fel_pkg::*;

    localparam logic [7:0]  CH_NUL   = 8'h00;
    localparam logic [7:0]  CH_DOT   = 8'h2E;
    localparam logic [7:0]  CH_SLASH = 8'h2F;
    localparam logic [63:0] SAT_LIMIT = {1'b0, INT_MAX};
    localparam int          REPORT_MAX = 10;

    typedef struct {
        kind_t                 kind;
        err_t                  err;
        logic [POS_WIDTH-1:0]  b_line;
        logic [POS_WIDTH-1:0]  b_col;
        logic [POS_WIDTH-1:0]  e_line;
        logic [POS_WIDTH-1:0]  e_col;
        logic [INT_WIDTH-1:0]  value;
        logic [7:0]            text_byte;
        logic [TEXT_CNT_W-1:0] text_len;
        logic                  trunc;
        logic                  last;
    } token_t;

    // ------------------------------------------------------------------------
    // Token predictor and store of expected results
    // ------------------------------------------------------------------------
    class token_scoreboard;
        mode_t                mode;
        bit                   primed;
        logic [7:0]           lookahead;
        logic [POS_WIDTH-1:0] line_pos, col_pos;
        logic [POS_WIDTH-1:0] tok_b_line, tok_b_col, tok_e_line, tok_e_col;
        logic [7:0]           text_buf [TEXT_MAX];
        int                   text_cnt;
        bit                   overflow;
        logic [63:0]          acc;
        token_t               expected_tokens [$];
        int                   failures;

        function new();
            mode       = M_NORMAL;
            primed     = 1'b0;
            lookahead  = 8'h00;
            line_pos   = POS_WIDTH'(1);
            col_pos    = '0;
            tok_b_line = POS_WIDTH'(1);
            tok_b_col  = '0;
            tok_e_line = POS_WIDTH'(1);
            tok_e_col  = '0;
            text_cnt   = 0;
            overflow   = 1'b0;
            acc        = 64'd0;
            failures   = 0;
        endfunction

        function bit is_num(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == " " || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function kind_t symbol_of(logic [7:0] c);
            case (c)
                "(":     return K_LPAR;
                ")":     return K_RPAR;
                "[":     return K_LSQUARE;
                "]":     return K_RSQUARE;
                ",":     return K_COMMA;
                ";":     return K_SEMICOLON;
                ":":     return K_COLON;
                "$":     return K_DOLLAR;
                default: return K_ERROR;
            endcase
        endfunction

        function void store_text(logic [7:0] c);
            if (text_cnt < TEXT_MAX) begin
                text_buf[text_cnt] = c;
                text_cnt++;
            end else begin
                overflow = 1'b1;
            end
        endfunction

        // Queue one result per buffered text byte, or one when there is none
        function void queue_token(kind_t kind, err_t err, logic [63:0] value,
                                  bit with_text);
            token_t t;
            int     n;
            int     runs;
            n    = with_text ? text_cnt : 0;
            runs = (n != 0) ? n : 1;
            for (int k = 0; k < runs; k++) begin
                t.kind      = kind;
                t.err       = err;
                t.b_line    = tok_b_line;
                t.b_col     = tok_b_col;
                t.e_line    = tok_e_line;
                t.e_col     = tok_e_col;
                t.value     = value[INT_WIDTH-1:0];
                t.text_byte = (n != 0) ? text_buf[k] : 8'h00;
                t.text_len  = TEXT_CNT_W'(n);
                t.trunc     = with_text && overflow;
                t.last      = (k == runs - 1);
                expected_tokens.insert(expected_tokens.size(), t);
            end
        endfunction

        function void mark_stop();
            tok_e_line = line_pos;
            tok_e_col  = col_pos;
        endfunction

        // Advance the lexer by one accepted byte
        function void take_byte(logic [7:0] ch);
            logic [7:0]  cur;
            logic [63:0] digit;
            kind_t       sym;
            bit          is_der;
            if (!primed) begin
                lookahead = ch;
                primed    = 1'b1;
                return;
            end
            cur       = lookahead;
            lookahead = ch;

            // advance position, LF moves to the next line
            if (col_pos < POS_MAX) col_pos++;
            if (cur == CH_LF) begin
                col_pos = '0;
                if (line_pos < POS_MAX) line_pos++;
            end

            if (mode == M_NORMAL) begin
                if (is_blank(cur)) return;
                tok_b_line = line_pos;
                tok_b_col  = col_pos;
                mark_stop();
                if (is_letter(cur)) begin
                    mode     = M_IDENT;
                    text_cnt = 0;
                    overflow = 1'b0;
                end else if (is_num(cur)) begin
                    mode = M_NUMBER;
                    acc  = 64'd0;
                end else if (cur == CH_SLASH) begin
                    mode     = M_REGEX;
                    text_cnt = 0;
                    overflow = 1'b0;
                    return;
                end else if (cur == CH_NUL) begin
                    mode = M_END;
                    queue_token(K_EOF, ERR_NONE, 64'd0, 1'b0);
                    return;
                end else begin
                    sym = symbol_of(cur);
                    queue_token(sym, (sym == K_ERROR) ? ERR_UNEXPECTED : ERR_NONE,
                                64'd0, 1'b0);
                    return;
                end
            end

            case (mode)
                M_IDENT: begin
                    mark_stop();
                    store_text(cur);
                    if (!is_num(ch) && !is_letter(ch) && ch != CH_DOT) begin
                        is_der = !overflow && text_cnt == 3 && text_buf[0] == "d" &&
                                 text_buf[1] == "e" && text_buf[2] == "r";
                        mode = M_NORMAL;
                        queue_token(is_der ? K_DER : K_IDENT, ERR_NONE, 64'd0, 1'b1);
                    end
                end
                M_NUMBER: begin
                    // accumulate, saturating at the 63-bit maximum
                    if (is_num(cur)) begin
                        digit = 64'(cur - "0");
                        mark_stop();
                        if (acc > (SAT_LIMIT - digit) / 10) acc = SAT_LIMIT;
                        else acc = acc * 10 + digit;
                    end
                    if (!is_num(ch)) begin
                        mark_stop();
                        mode = M_NORMAL;
                        queue_token(K_INT, ERR_NONE, acc, 1'b0);
                    end
                end
                M_REGEX: begin
                    if (cur == CH_SLASH) begin
                        mark_stop();
                        mode = M_NORMAL;
                        queue_token(K_REGEX, ERR_NONE, 64'd0, 1'b1);
                    end else if (cur == CH_NUL) begin
                        mark_stop();
                        mode = M_END;
                        queue_token(K_ERROR, ERR_REGEX_EOF, 64'd0, 1'b0);
                    end else begin
                        store_text(cur);
                    end
                end
                default: queue_token(K_EOF, ERR_NONE, 64'd0, 1'b0);
            endcase
        endfunction

        function string show(token_t t);
            return {$sformatf("kind=%0d err=%0d begin=%0d:%0d end=%0d:%0d int=%0d",
                              t.kind, t.err, t.b_line, t.b_col, t.e_line, t.e_col,
                              t.value),
                    $sformatf(" text=%02h len=%0d trunc=%b last=%b",
                              t.text_byte, t.text_len, t.trunc, t.last)};
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= REPORT_MAX) $display("%s", msg);
        endfunction

        // Compare one result transfer with the oldest expectation
        function void check_token(token_t got);
            token_t want;
            if (expected_tokens.size() == 0) begin
                flag({"unexpected result: ", show(got)});
                return;
            end
            want = expected_tokens.pop_front();
            if (got.kind !== want.kind || got.err !== want.err ||
                got.b_line !== want.b_line || got.b_col !== want.b_col ||
                got.e_line !== want.e_line || got.e_col !== want.e_col ||
                got.value !== want.value || got.text_byte !== want.text_byte ||
                got.text_len !== want.text_len || got.trunc !== want.trunc ||
                got.last !== want.last)
                flag({"mismatch: expected ", show(want), " got ", show(got)});
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function void close_out();
            if (expected_tokens.size() != 0)
                flag($sformatf("%0d expected results never arrived",
                               expected_tokens.size()));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block signals
    // ------------------------------------------------------------------------
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_ch = 8'h00;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [3:0]            m_kind;
    logic [1:0]            m_error_code;
    logic [POS_WIDTH-1:0]  m_begin_line;
    logic [POS_WIDTH-1:0]  m_begin_col;
    logic [POS_WIDTH-1:0]  m_end_line;
    logic [POS_WIDTH-1:0]  m_end_col;
    logic [INT_WIDTH-1:0]  m_int_value;
    logic [7:0]            m_text_byte;
    logic [TEXT_CNT_W-1:0] m_text_length;
    logic                  m_text_truncated;
    logic                  m_last;

    token_scoreboard sb;
    logic [7:0]      source_bytes [$];
    bit              steady = 1'b0;
    int              ready_left = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    filter_expression_lexer_top DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_ch             (s_ch),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_error_code     (m_error_code),
        .m_begin_line     (m_begin_line),
        .m_begin_col      (m_begin_col),
        .m_end_line       (m_end_line),
        .m_end_col        (m_end_col),
        .m_int_value      (m_int_value),
        .m_text_byte      (m_text_byte),
        .m_text_length    (m_text_length),
        .m_text_truncated (m_text_truncated),
        .m_last           (m_last)
    );

    // Mostly short gaps, a few long ones
    function automatic int idle_length(bit allow_zero);
        int r;
        r = $urandom_range(0, 99);
        if (allow_zero && r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Toggle m_ready between random ready windows and stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_left <= 0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else if (m_ready) begin
            m_ready    <= 1'b0;
            ready_left <= idle_length(1'b0) - 1;
        end else begin
            m_ready    <= 1'b1;
            ready_left <= $urandom_range(0, 7);
        end
    end

    // Check every result transfer
    always @(posedge aclk) begin : watch_results
        token_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen.kind      = kind_t'(m_kind);
            seen.err       = err_t'(m_error_code);
            seen.b_line    = m_begin_line;
            seen.b_col     = m_begin_col;
            seen.e_line    = m_end_line;
            seen.e_col     = m_end_col;
            seen.value     = m_int_value;
            seen.text_byte = m_text_byte;
            seen.text_len  = m_text_length;
            seen.trunc     = m_text_truncated;
            seen.last      = m_last;
            sb.check_token(seen);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void add_byte(logic [7:0] b);
        source_bytes.insert(source_bytes.size(), b);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic logic [7:0] pick_char(string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    // Space, tab, LF, VT, FF or CR
    function automatic void add_blank();
        add_byte(pick_char(" \011\012\013\014\015"));
    endfunction

    // Append one random token, usually well formed
    function automatic void add_random_token();
        string      first_set;
        string      rest_set;
        logic [7:0] b;
        int         r;
        int         len;
        first_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        rest_set  = {first_set, "0123456789.."};
        r = $urandom_range(0, 99);
        if (r < 12) begin
            add_byte(pick_char("()[],;:$"));
        end else if (r < 35) begin
            if ($urandom_range(0, 99) < 15) begin
                add_text("der");
            end else begin
                len = ($urandom_range(0, 99) < 20) ? $urandom_range(30, 40)
                                                   : $urandom_range(1, 8);
                add_byte(pick_char(first_set));
                for (int i = 1; i < len; i++) add_byte(pick_char(rest_set));
            end
        end else if (r < 55) begin
            r = $urandom_range(0, 99);
            if (r < 20) add_text("9223372036854775807");
            else if (r < 40) add_text("9223372036854775808");
            else begin
                len = (r < 60) ? $urandom_range(19, 22) : $urandom_range(1, 5);
                for (int i = 0; i < len; i++) add_byte(pick_char("0123456789"));
            end
        end else if (r < 70) begin
            len = ($urandom_range(0, 99) < 20) ? $urandom_range(30, 40)
                                               : $urandom_range(0, 6);
            add_byte(CH_SLASH);
            for (int i = 0; i < len; i++) begin
                do b = 8'($urandom_range(1, 255)); while (b == CH_SLASH);
                add_byte(b);
            end
            add_byte(CH_SLASH);
        end else if (r < 80) begin
            add_byte(8'($urandom_range(1, 255)));
        end else begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) add_blank();
        end
        if ($urandom_range(0, 99) < 70) add_blank();
    endfunction

    // Transfer every queued byte, with random gaps unless no_idle is set
    task automatic send_stream(input bit no_idle);
        int gap;
        steady <= no_idle;
        while (source_bytes.size() != 0) begin
            gap = no_idle ? 0 : idle_length(1'b1);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_ch    <= source_bytes[0];
            do @(posedge aclk); while (!s_ready);
            sb.take_byte(source_bytes.pop_front());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // every symbol, keyword, identifier, unknown bytes, int and regex
        add_text("()[],;:$ der A_9.");
        add_byte(8'hFF);
        add_text("\t7\n/a");
        add_byte(8'hFE);
        add_text("/");
        send_stream(1'b0);

        // random tokens; middle chunk runs without idling
        for (int chunk = 0; chunk < 3; chunk++) begin
            while (source_bytes.size() < 125) add_random_token();
            send_stream(chunk == 1);
        end

        // end inside a regex, then end mode
        add_text("/ab");
        add_byte(CH_NUL);
        for (int i = 0; i < 4; i++) add_byte(8'($urandom_range(0, 255)));
        send_stream(1'b0);
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        sb.close_out();
        if (sb.failures == 0) begin
            $display("PASS filter_expression_lexer_top");
        end else begin
            $display("FAIL filter_expression_lexer_top");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #40_000_000;
        $display("FAIL filter_expression_lexer_top");
        $finish;
    end

endmodule
